// ===== rtl/rrs_pkg.sv =====
`default_nettype none
package rrs_pkg;

  // sizing
  localparam int MAX_PROCS_DEF = 16;
  localparam int TIME_W        = 21;
  localparam int VAL_W         = 16;
  localparam logic [TIME_W-1:0] TIME_MAX = 21'h1F_FFFF;
  localparam logic [VAL_W-1:0]  QUANTUM_RESET = 16'd4;

  // request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_STEP  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // slice kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_RUN  = 2'd1;
  localparam logic [1:0] KIND_IDLE = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/rrs_ram.sv =====
`default_nettype none
module rrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/round_robin_cpu_scheduler.sv =====
`default_nettype none
// channel   | signals                                        | handshake
// ----------+------------------------------------------------+-------------------------
// request   | req_type, arrival_time, burst_time             | start & !busy
// result    | slice_kind, proc_id, slice_end_time, finished, | result_valid, one cycle
//           | turnaround, waiting, all_done, status          |
// config    | cfg_wdata (quantum)                            | cfg_we
//
// clear, unused codes, rejected loads, empty or finished steps: result in the next cycle.
// load: per entry compared, an order read and an arrival test; a put if it goes first.
// step: busy for the walk over the arrival order memory, one order read and one
// process table read per entry, both memories with a registered read port; an idle
// tick walks only up to the entry it queues. reset is synchronous; the memories need
// no clearing pass.
// results cannot be stalled: result_valid marks each for exactly one cycle.
module round_robin_cpu_scheduler #(
  parameter int MAX_PROCS = rrs_pkg::MAX_PROCS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 req_type,
  input  logic [rrs_pkg::VAL_W-1:0]  arrival_time,
  input  logic [rrs_pkg::VAL_W-1:0]  burst_time,
  input  logic                       cfg_we,
  input  logic [rrs_pkg::VAL_W-1:0]  cfg_wdata,
  output logic                       result_valid,
  output logic [1:0]                 slice_kind,
  output logic [3:0]                 proc_id,
  output logic [rrs_pkg::TIME_W-1:0] slice_end_time,
  output logic                       finished,
  output logic [rrs_pkg::TIME_W-1:0] turnaround,
  output logic [rrs_pkg::TIME_W-1:0] waiting,
  output logic                       all_done,
  output logic [1:0]                 status
);
  import rrs_pkg::*;

  localparam int IW  = $clog2(MAX_PROCS);
  localparam int CW  = $clog2(MAX_PROCS + 1);
  localparam int LDEPTH = 2 * MAX_PROCS;
  localparam int LAW = $clog2(LDEPTH);
  localparam int PW  = 3 * VAL_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LD_ORD  = 4'd1;
  localparam logic [3:0] S_LD_ARR  = 4'd2;
  localparam logic [3:0] S_LD_PUT  = 4'd3;
  localparam logic [3:0] S_FST_ORD = 4'd4;
  localparam logic [3:0] S_FST_ARR = 4'd5;
  localparam logic [3:0] S_POP_ID  = 4'd6;
  localparam logic [3:0] S_POP_RD  = 4'd7;
  localparam logic [3:0] S_POP_TAT = 4'd8;
  localparam logic [3:0] S_POP_WT  = 4'd9;
  localparam logic [3:0] S_SC_ORD  = 4'd10;
  localparam logic [3:0] S_SC_ARR  = 4'd11;
  localparam logic [3:0] S_RUN_END = 4'd12;

  // control state
  logic [3:0]           state, state_next;
  logic [VAL_W-1:0]     quantum;
  logic [MAX_PROCS-1:0] completed, completed_next;
  logic [MAX_PROCS-1:0] queued, queued_next;
  logic [IW-1:0]        head, head_next, tail, tail_next;
  logic [CW-1:0]        fcount, fcount_next;
  logic [CW-1:0]        loaded, loaded_next;
  logic [CW-1:0]        done_cnt, done_cnt_next;
  logic [TIME_W-1:0]    now, now_next;
  logic                 started, started_next;

  // working registers
  logic [IW-1:0]     cnt, cnt_next;
  logic [VAL_W-1:0]  at_r, at_r_next;
  logic [IW-1:0]     qv, qv_next;
  logic [IW-1:0]     pid, pid_next;
  logic [VAL_W-1:0]  arr_r, arr_r_next, burst_r, burst_r_next, rem_r, rem_r_next;
  logic              fin_r, fin_r_next;
  logic [TIME_W-1:0] tat_r, tat_r_next, wt_r, wt_r_next;
  logic              idle_mode, idle_mode_next;

  // memory ports
  logic           list_we;
  logic [LAW-1:0] list_waddr, list_raddr;
  logic [IW-1:0]  list_wdata, list_rdata;
  logic           proc_we;
  logic [IW-1:0]  proc_waddr, proc_raddr;
  logic [PW-1:0]  proc_wdata, proc_rdata;

  // result staging
  logic              emit;
  logic [1:0]        e_kind, e_status;
  logic [IW-1:0]     e_id;
  logic              e_fin;
  logic [TIME_W-1:0] e_tat, e_wt;

  logic              push_en;
  logic [IW-1:0]     push_id;

  logic [VAL_W-1:0]  q_eff, rd_arr, rd_burst, rd_rem, slice_len, rem_new;
  logic [TIME_W:0]   now_sum;
  logic              hit, last;

  // arrival order at [0, MAX_PROCS), ready ring at [MAX_PROCS, 2*MAX_PROCS)
  rrs_ram #(.WIDTH(IW), .DEPTH(LDEPTH)) u_list (
    .clk(clk), .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
    .raddr(list_raddr), .rdata(list_rdata)
  );

  // process table: arrival, burst, remaining
  rrs_ram #(.WIDTH(PW), .DEPTH(MAX_PROCS)) u_proc (
    .clk(clk), .we(proc_we), .waddr(proc_waddr), .wdata(proc_wdata),
    .raddr(proc_raddr), .rdata(proc_rdata)
  );

  assign busy     = (state != S_IDLE);
  assign q_eff    = (quantum == '0) ? VAL_W'(1) : quantum;
  assign rd_arr   = proc_rdata[PW-1 -: VAL_W];
  assign rd_burst = proc_rdata[2*VAL_W-1 -: VAL_W];
  assign rd_rem   = proc_rdata[VAL_W-1:0];

  // sequencer
  always_comb begin
    state_next     = state;
    completed_next = completed;
    queued_next    = queued;
    head_next      = head;
    tail_next      = tail;
    fcount_next    = fcount;
    loaded_next    = loaded;
    done_cnt_next  = done_cnt;
    now_next       = now;
    started_next   = started;
    cnt_next       = cnt;
    at_r_next      = at_r;
    qv_next        = qv;
    pid_next       = pid;
    arr_r_next     = arr_r;
    burst_r_next   = burst_r;
    rem_r_next     = rem_r;
    fin_r_next     = fin_r;
    tat_r_next     = tat_r;
    wt_r_next      = wt_r;
    idle_mode_next = idle_mode;
    list_we        = 1'b0;
    list_waddr     = '0;
    list_wdata     = '0;
    list_raddr     = '0;
    proc_we        = 1'b0;
    proc_waddr     = '0;
    proc_wdata     = '0;
    proc_raddr     = '0;
    push_en        = 1'b0;
    push_id        = '0;
    emit           = 1'b0;
    e_kind         = KIND_NONE;
    e_status       = STATUS_OK;
    e_id           = '0;
    e_fin          = 1'b0;
    e_tat          = '0;
    e_wt           = '0;
    slice_len      = (rd_rem < q_eff) ? rd_rem : q_eff;
    rem_new        = rd_rem - slice_len;
    now_sum        = {1'b0, now} + (TIME_W + 1)'(slice_len);
    hit            = ((TIME_W'(rd_arr) <= now) && !completed[qv]
                      && (idle_mode || ((qv != pid) && !queued[qv])));
    last           = ((CW'(cnt) + CW'(1)) == loaded);

    case (state)
      S_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_LOAD: begin
              at_r_next = arrival_time;
              if (loaded == CW'(MAX_PROCS)) begin
                emit     = 1'b1;
                e_status = STATUS_FULL;
              end else begin
                proc_we    = 1'b1;
                proc_waddr = IW'(loaded);
                proc_wdata = {arrival_time, burst_time, burst_time};
                if (loaded == '0) begin
                  list_we     = 1'b1;
                  loaded_next = CW'(1);
                  emit        = 1'b1;
                end else begin
                  cnt_next   = IW'(loaded - CW'(1));
                  list_raddr = LAW'(loaded - CW'(1));
                  state_next = S_LD_ORD;
                end
              end
            end
            REQ_STEP: begin
              if (loaded == '0) begin
                emit     = 1'b1;
                e_status = STATUS_EMPTY;
              end else if (done_cnt >= loaded) begin
                emit = 1'b1;
              end else if (!started) begin
                started_next = 1'b1;
                state_next   = S_FST_ORD;
              end else if (fcount == '0) begin
                now_next       = (now == TIME_MAX) ? now : now + TIME_W'(1);
                cnt_next       = '0;
                idle_mode_next = 1'b1;
                state_next     = S_SC_ORD;
              end else begin
                list_raddr = LAW'(MAX_PROCS) + LAW'(head);
                state_next = S_POP_ID;
              end
            end
            REQ_CLEAR: begin
              completed_next = '0;
              queued_next    = '0;
              head_next      = '0;
              tail_next      = '0;
              fcount_next    = '0;
              loaded_next    = '0;
              done_cnt_next  = '0;
              now_next       = '0;
              started_next   = 1'b0;
              emit           = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      // insertion: move later arrivals up one place
      S_LD_ORD: begin
        qv_next    = list_rdata;
        proc_raddr = list_rdata;
        state_next = S_LD_ARR;
      end
      S_LD_ARR: begin
        list_we    = 1'b1;
        list_waddr = LAW'(cnt) + LAW'(1);
        if (rd_arr > at_r) begin
          list_wdata = qv;
          if (cnt == '0) begin
            state_next = S_LD_PUT;
          end else begin
            cnt_next   = cnt - IW'(1);
            list_raddr = LAW'(cnt - IW'(1));
            state_next = S_LD_ORD;
          end
        end else begin
          list_wdata  = IW'(loaded);
          loaded_next = loaded + CW'(1);
          emit        = 1'b1;
          e_id        = IW'(loaded);
          state_next  = S_IDLE;
        end
      end
      S_LD_PUT: begin
        list_we     = 1'b1;
        list_wdata  = IW'(loaded);
        loaded_next = loaded + CW'(1);
        emit        = 1'b1;
        e_id        = IW'(loaded);
        state_next  = S_IDLE;
      end
      // first step: queue the earliest process
      S_FST_ORD: begin
        push_en    = 1'b1;
        push_id    = list_rdata;
        proc_raddr = list_rdata;
        state_next = S_FST_ARR;
      end
      S_FST_ARR: begin
        if (TIME_W'(rd_arr) > now) begin
          now_next   = TIME_W'(rd_arr);
          emit       = 1'b1;
          e_kind     = KIND_IDLE;
          state_next = S_IDLE;
        end else begin
          list_raddr = LAW'(MAX_PROCS) + LAW'(head);
          state_next = S_POP_ID;
        end
      end
      // pop the ready ring head
      S_POP_ID: begin
        pid_next              = list_rdata;
        head_next             = (head == IW'(MAX_PROCS - 1)) ? '0 : head + IW'(1);
        fcount_next           = fcount - CW'(1);
        queued_next[list_rdata] = 1'b0;
        proc_raddr            = list_rdata;
        state_next            = S_POP_RD;
      end
      // run the slice and write back the remaining time
      S_POP_RD: begin
        now_next     = (now_sum > {1'b0, TIME_MAX}) ? TIME_MAX : now_sum[TIME_W-1:0];
        proc_we      = 1'b1;
        proc_waddr   = pid;
        proc_wdata   = {rd_arr, rd_burst, rem_new};
        arr_r_next   = rd_arr;
        burst_r_next = rd_burst;
        rem_r_next   = rem_new;
        fin_r_next   = (rem_new == '0);
        if (rem_new == '0) begin
          completed_next[pid] = 1'b1;
          done_cnt_next       = done_cnt + CW'(1);
        end
        state_next = S_POP_TAT;
      end
      S_POP_TAT: begin
        tat_r_next = (now >= TIME_W'(arr_r)) ? now - TIME_W'(arr_r) : '0;
        state_next = S_POP_WT;
      end
      S_POP_WT: begin
        wt_r_next      = (tat_r >= TIME_W'(burst_r)) ? tat_r - TIME_W'(burst_r) : '0;
        cnt_next       = '0;
        idle_mode_next = 1'b0;
        state_next     = S_SC_ORD;
      end
      // walk the arrival order
      S_SC_ORD: begin
        qv_next    = list_rdata;
        proc_raddr = list_rdata;
        state_next = S_SC_ARR;
      end
      S_SC_ARR: begin
        if (hit) begin
          push_en = 1'b1;
          push_id = qv;
        end
        if (idle_mode && (hit || last)) begin
          emit       = 1'b1;
          e_kind     = KIND_IDLE;
          state_next = S_IDLE;
        end else if (last) begin
          state_next = S_RUN_END;
        end else begin
          cnt_next   = cnt + IW'(1);
          list_raddr = LAW'(cnt) + LAW'(1);
          state_next = S_SC_ORD;
        end
      end
      // requeue the preempted process and report
      S_RUN_END: begin
        if (rem_r != '0) begin
          push_en = 1'b1;
          push_id = pid;
        end
        emit       = 1'b1;
        e_kind     = KIND_RUN;
        e_id       = pid;
        e_fin      = fin_r;
        e_tat      = fin_r ? tat_r : '0;
        e_wt       = fin_r ? wt_r : '0;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // ready ring push
    if (push_en && (fcount < CW'(MAX_PROCS))) begin
      list_we              = 1'b1;
      list_waddr           = LAW'(MAX_PROCS) + LAW'(tail);
      list_wdata           = push_id;
      tail_next            = (tail == IW'(MAX_PROCS - 1)) ? '0 : tail + IW'(1);
      fcount_next          = fcount + CW'(1);
      queued_next[push_id] = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      completed    <= '0;
      queued       <= '0;
      head         <= '0;
      tail         <= '0;
      fcount       <= '0;
      loaded       <= '0;
      done_cnt     <= '0;
      now          <= '0;
      started      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      completed    <= completed_next;
      queued       <= queued_next;
      head         <= head_next;
      tail         <= tail_next;
      fcount       <= fcount_next;
      loaded       <= loaded_next;
      done_cnt     <= done_cnt_next;
      now          <= now_next;
      started      <= started_next;
      result_valid <= emit;
    end
  end

  // quantum register
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RESET;
    end else if (cfg_we) begin
      quantum <= cfg_wdata;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cnt       <= cnt_next;
    at_r      <= at_r_next;
    qv        <= qv_next;
    pid       <= pid_next;
    arr_r     <= arr_r_next;
    burst_r   <= burst_r_next;
    rem_r     <= rem_r_next;
    fin_r     <= fin_r_next;
    tat_r     <= tat_r_next;
    wt_r      <= wt_r_next;
    idle_mode <= idle_mode_next;
  end

  // result transaction
  always_ff @(posedge clk) begin
    if (emit) begin
      slice_kind     <= e_kind;
      proc_id        <= 4'(e_id);
      slice_end_time <= now_next;
      finished       <= e_fin;
      turnaround     <= e_tat;
      waiting        <= e_wt;
      all_done       <= (loaded_next != '0) && (done_cnt_next >= loaded_next);
      status         <= e_status;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rrs_checker.sv =====
`default_nettype none
module rrs_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_valid,
  input logic [1:0] slice_kind,
  input logic [3:0] proc_id,
  input logic       finished,
  input logic [1:0] status
);
  import rrs_pkg::*;

  // reset leaves the block idle with no result
  a_reset: assert property (@(posedge clk) rst |=> (!busy && !result_valid))
    else $error("block not idle after reset");

  // an accepted transaction either reports at once or holds busy
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (result_valid || busy))
    else $error("accepted transaction dropped");

  // only a running slice completes a process
  a_fin_run: assert property (@(posedge clk) disable iff (rst)
    (result_valid && finished) |-> (slice_kind == KIND_RUN))
    else $error("completion outside a running slice");

  // an error status carries no slice
  a_err_none: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status != STATUS_OK)) |-> (slice_kind == KIND_NONE))
    else $error("slice reported with error status");

  // an idle slice names no process
  a_idle_id: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (slice_kind == KIND_IDLE)) |-> (proc_id == 4'd0 && !finished))
    else $error("idle slice with process fields");

endmodule

bind round_robin_cpu_scheduler rrs_checker u_rrs_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .result_valid(result_valid),
  .slice_kind(slice_kind), .proc_id(proc_id), .finished(finished), .status(status)
);
`default_nettype wire

// ===== sim/tb_round_robin_cpu_scheduler.sv =====
`timescale 1ns / 1ps
module tb_round_robin_cpu_scheduler;
  import rrs_pkg::*;

  localparam int NPROC      = 16;
  localparam int DRAIN_WAIT = 80;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]        kind;
    logic [3:0]        id;
    logic [TIME_W-1:0] tend;
    logic              fin;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
    logic              alld;
    logic [1:0]        st;
  } slice_rep_t;

  typedef struct {
    logic [1:0]       req;
    logic [VAL_W-1:0] at;
    logic [VAL_W-1:0] bt;
    bit               typed;
    slice_rep_t       rep;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type = REQ_LOAD;
  logic [VAL_W-1:0] arrival_time = '0;
  logic [VAL_W-1:0] burst_time = '0;
  logic cfg_we = 1'b0;
  logic [VAL_W-1:0] cfg_wdata = '0;
  logic result_valid;
  logic [1:0] slice_kind;
  logic [3:0] proc_id;
  logic [TIME_W-1:0] slice_end_time;
  logic finished;
  logic [TIME_W-1:0] turnaround;
  logic [TIME_W-1:0] waiting;
  logic all_done;
  logic [1:0] status;

  round_robin_cpu_scheduler u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .arrival_time(arrival_time), .burst_time(burst_time),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .result_valid(result_valid), .slice_kind(slice_kind), .proc_id(proc_id),
    .slice_end_time(slice_end_time), .finished(finished), .turnaround(turnaround),
    .waiting(waiting), .all_done(all_done), .status(status)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler shadow state
  logic [VAL_W-1:0] sh_quantum;
  logic [VAL_W-1:0] sh_arr [NPROC];
  logic [VAL_W-1:0] sh_burst [NPROC];
  logic [VAL_W-1:0] sh_rem [NPROC];
  logic [3:0] sh_order [NPROC];
  logic [3:0] sh_fifo [NPROC];
  logic [NPROC-1:0] sh_done_mask, sh_queued_mask;
  logic [3:0] sh_head, sh_tail;
  int sh_fcount, sh_loaded, sh_ndone;
  int sh_now;
  bit sh_started;

  slice_rep_t slices_due[$];
  int mismatch_cnt = 0;
  int idle_pct = 0;

  function automatic void sched_clear();
    sh_done_mask = '0;
    sh_queued_mask = '0;
    sh_head = '0;
    sh_tail = '0;
    sh_fcount = 0;
    sh_loaded = 0;
    sh_ndone = 0;
    sh_now = 0;
    sh_started = 0;
  endfunction

  function automatic bit sched_all_done();
    return sh_loaded > 0 && sh_ndone >= sh_loaded;
  endfunction

  function automatic void ready_push(int p);
    if (sh_fcount >= NPROC) return;
    sh_fifo[sh_tail] = p[3:0];
    sh_tail = sh_tail + 4'd1;
    sh_fcount++;
    sh_queued_mask[p] = 1'b1;
  endfunction

  function automatic slice_rep_t make_rep(logic [1:0] k, int id, bit fin, int tat, int wt,
                                          logic [1:0] st);
    slice_rep_t r;
    r.kind = k;
    r.id = id[3:0];
    r.tend = sh_now[TIME_W-1:0];
    r.fin = fin;
    r.tat = tat[TIME_W-1:0];
    r.wt = wt[TIME_W-1:0];
    r.alld = sched_all_done();
    r.st = st;
    return r;
  endfunction

  // predicts the report for one transaction and advances the shadow state
  function automatic slice_rep_t sched_predict(logic [1:0] req, logic [VAL_W-1:0] at,
                                               logic [VAL_W-1:0] bt);
    int idx, pos, p, q, t, tat, wt;
    bit fin;
    tat = 0;
    wt = 0;
    fin = 0;
    if (req == REQ_LOAD) begin
      idx = sh_loaded;
      if (idx >= NPROC) return make_rep(KIND_NONE, 0, 0, 0, 0, STATUS_FULL);
      sh_arr[idx] = at;
      sh_burst[idx] = bt;
      sh_rem[idx] = bt;
      pos = 0;
      while (pos < idx && sh_arr[sh_order[pos]] <= at) pos++;
      for (int j = idx; j > pos; j--) sh_order[j] = sh_order[j-1];
      sh_order[pos] = idx[3:0];
      sh_loaded = idx + 1;
      return make_rep(KIND_NONE, idx, 0, 0, 0, STATUS_OK);
    end
    if (req == REQ_CLEAR) begin
      sched_clear();
      return make_rep(KIND_NONE, 0, 0, 0, 0, STATUS_OK);
    end
    if (req != REQ_STEP) return make_rep(KIND_NONE, 0, 0, 0, 0, STATUS_OK);
    if (sh_loaded == 0) return make_rep(KIND_NONE, 0, 0, 0, 0, STATUS_EMPTY);
    if (sched_all_done()) return make_rep(KIND_NONE, 0, 0, 0, 0, STATUS_OK);
    // first step: idle up to the earliest arrival
    if (!sh_started) begin
      p = sh_order[0];
      sh_started = 1;
      ready_push(p);
      if (sh_arr[p] > sh_now) begin
        sh_now = sh_arr[p];
        return make_rep(KIND_IDLE, 0, 0, 0, 0, STATUS_OK);
      end
    end
    // nothing ready: idle tick
    if (sh_fcount == 0) begin
      if (sh_now < TIME_MAX) sh_now++;
      for (int i = 0; i < sh_loaded; i++) begin
        q = sh_order[i];
        if (sh_arr[q] <= sh_now && !sh_done_mask[q]) begin
          ready_push(q);
          break;
        end
      end
      return make_rep(KIND_IDLE, 0, 0, 0, 0, STATUS_OK);
    end
    p = sh_fifo[sh_head];
    sh_head = sh_head + 4'd1;
    sh_fcount--;
    sh_queued_mask[p] = 1'b0;
    t = (sh_quantum == 0) ? 1 : sh_quantum;
    if (sh_rem[p] < t) t = sh_rem[p];
    sh_rem[p] = sh_rem[p] - t[VAL_W-1:0];
    sh_now = (sh_now + t > TIME_MAX) ? TIME_MAX : sh_now + t;
    if (sh_rem[p] == 0) begin
      fin = 1;
      sh_done_mask[p] = 1'b1;
      sh_ndone++;
      tat = (sh_now >= sh_arr[p]) ? sh_now - sh_arr[p] : 0;
      wt = (tat >= sh_burst[p]) ? tat - sh_burst[p] : 0;
    end
    // arrivals first, then the preempted process
    for (int i = 0; i < sh_loaded; i++) begin
      q = sh_order[i];
      if (q != p && sh_arr[q] <= sh_now && !sh_done_mask[q] && !sh_queued_mask[q])
        ready_push(q);
    end
    if (sh_rem[p] > 0) ready_push(p);
    return make_rep(KIND_RUN, p, fin, tat, wt, STATUS_OK);
  endfunction

  // one transaction on the request side, with random idling before it
  task automatic issue(logic [1:0] req, logic [VAL_W-1:0] at, logic [VAL_W-1:0] bt,
                       bit typed = 0, slice_rep_t typed_rep = '0);
    slice_rep_t r;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= req;
    arrival_time <= at;
    burst_time <= bt;
    do @(posedge clk); while (busy);
    r = sched_predict(req, at, bt);
    slices_due.push_back(typed ? typed_rep : r);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (slices_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_quantum(logic [VAL_W-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sh_quantum = v;
    cfg_we <= 1'b0;
    cfg_wdata <= VAL_W'($urandom);
  endtask

  task automatic check_field(string name, logic [TIME_W-1:0] exp_v, logic [TIME_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s expected %0d actual %0d", $realtime, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // result checking
  always @(posedge clk) begin
    slice_rep_t e;
    if (!rst && result_valid) begin
      if (slices_due.size() == 0) begin
        $display("%0t unexpected result transaction, kind %0d id %0d", $realtime,
                 slice_kind, proc_id);
        mismatch_cnt++;
      end else begin
        e = slices_due.pop_front();
        check_field("slice_kind", e.kind, slice_kind);
        check_field("proc_id", e.id, proc_id);
        check_field("slice_end_time", e.tend, slice_end_time);
        check_field("finished", e.fin, finished);
        check_field("turnaround", e.tat, turnaround);
        check_field("waiting", e.wt, waiting);
        check_field("all_done", e.alld, all_done);
        check_field("status", e.st, status);
      end
    end
  end

  // watchdog on cycles with no transaction
  int stall_cnt = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || cfg_we) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  function automatic dir_row_t row(logic [1:0] req, int at, int bt, bit typed = 0,
                                   logic [1:0] k = KIND_NONE, int id = 0,
                                   logic [1:0] st = STATUS_OK);
    dir_row_t d;
    d.req = req;
    d.at = at[VAL_W-1:0];
    d.bt = bt[VAL_W-1:0];
    d.typed = typed;
    d.rep = '0;
    d.rep.kind = k;
    d.rep.id = id[3:0];
    d.rep.st = st;
    return d;
  endfunction

  // random workload: mostly load-then-run sets, some noise
  task automatic run_phase(int n_items);
    int cnt, nld, nstep, at, bt;
    cnt = 0;
    while (cnt < n_items) begin
      if ($urandom_range(9) < 8) begin
        issue(REQ_CLEAR, VAL_W'($urandom), VAL_W'($urandom));
        nld = ($urandom_range(7) == 0) ? 17 : $urandom_range(1, NPROC);
        cnt += nld + 1;
        repeat (nld) begin
          at = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(40);
          bt = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(20);
          issue(REQ_LOAD, VAL_W'(at), VAL_W'(bt));
        end
        nstep = 0;
        while (nstep < 90 && cnt < n_items
               && !(sched_all_done() && $urandom_range(2) == 0)) begin
          if (sh_loaded < NPROC && $urandom_range(15) == 0)
            issue(REQ_LOAD, sh_now[VAL_W-1:0] + VAL_W'($urandom_range(10)),
                  VAL_W'($urandom_range(12)));
          else
            issue(REQ_STEP, VAL_W'($urandom), VAL_W'($urandom));
          nstep++;
          cnt++;
        end
      end else begin
        repeat (6) issue(2'($urandom_range(3)), VAL_W'($urandom), VAL_W'($urandom));
        cnt += 6;
      end
    end
  endtask

  dir_row_t dir_tab[$];
  logic [VAL_W-1:0] quanta [6];

  initial begin
    sh_quantum = QUANTUM_RESET;
    sched_clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty step, unused code, extremes, table full, zero burst, late idle start
    dir_tab.push_back(row(REQ_STEP, 0, 0, 1, KIND_NONE, 0, STATUS_EMPTY));
    dir_tab.push_back(row(2'd3, 65535, 65535, 1));
    dir_tab.push_back(row(REQ_LOAD, 0, 0, 1, KIND_NONE, 0));
    dir_tab.push_back(row(REQ_LOAD, 65535, 65535, 1, KIND_NONE, 1));
    dir_tab.push_back(row(REQ_LOAD, 0, 5));
    dir_tab.push_back(row(REQ_LOAD, 2, 3));
    dir_tab.push_back(row(REQ_LOAD, 2, 1));
    dir_tab.push_back(row(REQ_LOAD, 1, 9));
    dir_tab.push_back(row(REQ_LOAD, 7, 4));
    dir_tab.push_back(row(REQ_LOAD, 3, 2));
    dir_tab.push_back(row(REQ_LOAD, 40, 6));
    dir_tab.push_back(row(REQ_LOAD, 12, 8));
    dir_tab.push_back(row(REQ_LOAD, 5, 1));
    dir_tab.push_back(row(REQ_LOAD, 9, 4));
    dir_tab.push_back(row(REQ_LOAD, 0, 7));
    dir_tab.push_back(row(REQ_LOAD, 30, 2));
    dir_tab.push_back(row(REQ_LOAD, 6, 3));
    dir_tab.push_back(row(REQ_LOAD, 4, 5));
    dir_tab.push_back(row(REQ_LOAD, 100, 100, 1, KIND_NONE, 0, STATUS_FULL));
    repeat (3) dir_tab.push_back(row(REQ_STEP, 0, 0));
    dir_tab.push_back(row(REQ_CLEAR, 0, 0, 1));
    dir_tab.push_back(row(REQ_LOAD, 5, 1));
    repeat (3) dir_tab.push_back(row(REQ_STEP, 0, 0));
    foreach (dir_tab[i]) issue(dir_tab[i].req, dir_tab[i].at, dir_tab[i].bt,
                               dir_tab[i].typed, dir_tab[i].rep);

    // random phases over several quantum settings
    quanta[0] = 16'd1;
    quanta[1] = 16'd0;
    quanta[2] = 16'hFFFF;
    quanta[3] = VAL_W'($urandom_range(2, 9));
    quanta[4] = VAL_W'($urandom);
    quanta[5] = 16'd3;
    for (int ph = 0; ph < 6; ph++) begin
      set_quantum(quanta[ph]);
      idle_pct = (ph < 2) ? 23 : (ph < 4) ? 68 : 0;
      run_phase(190);
    end

    wait_drained();
    if (mismatch_cnt == 0 && slices_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
